// ===== src/dpmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpmt_pkg
// Shared types and codes for the dual-port mailbox table.
// ----------------------------------------------------------------------------
package dpmt_pkg;

  // Field widths of the stream words and the scan count
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = 6;

  // Request opcodes
  localparam logic [1:0] OP_SEND     = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_REGISTER = 2'd2;
  localparam logic [1:0] OP_POLL     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_EMIT
  } dpmt_state_t;

endpackage

// ===== src/dpmt_ram.sv =====
// ----------------------------------------------------------------------------
// dpmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpmt_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/dual_port_mailbox_table_core.sv =====
// ----------------------------------------------------------------------------
// dual_port_mailbox_table_core
// Mailbox table with handler marks, doorbell flag and a scanning poll.
// ----------------------------------------------------------------------------
// One request word is taken at a time; in_tready is high only while the
// sequencer is idle. Mailbox words sit in a RAM with one read and one write
// port, so the RAM read latency sets the timing: clear and register go
// straight to the result word, send passes read, check and write, result,
// and poll scans its N mailboxes, reading one mailbox per cycle between
// reported entries and pausing for each entry it reports until the result
// register is free. The result register lets the next request in while a
// finished word waits on out_tready. After reset the table reads as all
// zero at once (per-entry valid bits), with no clearing pass.
module dual_port_mailbox_table_core
  import dpmt_pkg::*;
#(
  parameter int unsigned MAILBOXES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: active_count
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode
  input  logic [23:0] in_tdata,   // mailbox_index[4:0], send_value[20:5],
                                  // handler_present[21], zero pad
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // result_kind
  output logic        out_tlast,  // last
  output logic [23:0] out_tdata   // accepted[0], entry_index[5:1],
                                  // entry_data[21:6], doorbell[22], zero pad
);

  // only 32 mailboxes are addressable by a 5-bit index
  localparam int unsigned DEPTH = (MAILBOXES < 32) ? MAILBOXES : 32;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // request fields
  logic [IDX_W-1:0]         in_idx;
  logic signed [DATA_W-1:0] in_data;
  logic                     in_present;
  logic                     in_inside;

  assign in_idx     = in_tdata[4:0];
  assign in_data    = in_tdata[20:5];
  assign in_present = in_tdata[21];
  assign in_inside  = (CNT_W'(in_idx) < DEPTH_C);

  // state
  dpmt_state_t              state_r, state_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     inside_r, inside_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic [CW-1:0]            ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         active_count_r;
  logic                     doorbell_r, doorbell_nxt;
  logic [DEPTH-1:0]         vld_r, vld_nxt;
  logic [DEPTH-1:0]         mark_r, mark_nxt;

  // pending result
  logic [1:0]               pkind_r, pkind_nxt;
  logic                     pacc_r, pacc_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  logic signed [DATA_W-1:0] pdata_r, pdata_nxt;
  logic                     plast_r, plast_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r, out_kind_nxt;
  logic                     out_acc_r, out_acc_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     out_bell_r, out_bell_nxt;
  logic                     out_last_r, out_last_nxt;

  // RAM port
  logic                     ram_wr_en;
  logic [AW-1:0]            ram_rd_addr;
  logic signed [DATA_W-1:0] ram_rd_data;

  // scan helpers
  logic [CW-1:0] limit;
  logic [CW-1:0] ptr_inc;
  logic          out_free;
  logic          word_zero;
  logic          send_ok;
  logic          hit;

  assign limit    = (active_count_r > DEPTH_C) ? CW'(DEPTH) : CW'(active_count_r);
  assign ptr_inc  = ptr_r + 1'b1;
  assign out_free = !out_valid_r || out_tready;

  assign word_zero = !vld_r[idx_r] || (ram_rd_data == '0);
  assign send_ok   = inside_r && word_zero;
  assign hit       = mark_r[ptr_r[AW-1:0]] && vld_r[ptr_r[AW-1:0]] &&
                     (ram_rd_data != '0);

  dpmt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_words (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx_r),
    .wr_data (data_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    inside_nxt    = inside_r;
    data_nxt      = data_r;
    ptr_nxt       = ptr_r;
    doorbell_nxt  = doorbell_r;
    vld_nxt       = vld_r;
    mark_nxt      = mark_r;
    pkind_nxt     = pkind_r;
    pacc_nxt      = pacc_r;
    pidx_nxt      = pidx_r;
    pdata_nxt     = pdata_r;
    plast_nxt     = plast_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_acc_nxt   = out_acc_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    out_bell_nxt  = out_bell_r;
    out_last_nxt  = out_last_r;
    ram_wr_en     = 1'b0;
    ram_rd_addr   = ptr_r[AW-1:0];
    in_tready     = (state_r == ST_IDLE);

    // result word taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt    = in_idx[AW-1:0];
          inside_nxt = in_inside;
          data_nxt   = in_data;
          pacc_nxt   = 1'b0;
          pidx_nxt   = '0;
          pdata_nxt  = '0;
          plast_nxt  = 1'b1;
          case (in_tuser)
            OP_SEND: begin
              ram_rd_addr = in_idx[AW-1:0];
              state_nxt   = ST_LOOK;
            end
            OP_CLEAR, OP_REGISTER: begin
              if (in_inside) begin
                vld_nxt[in_idx[AW-1:0]] = 1'b0;
                if (in_tuser == OP_REGISTER) begin
                  mark_nxt[in_idx[AW-1:0]] = in_present;
                end
              end
              pkind_nxt = KIND_ACK;
              state_nxt = ST_EMIT;
            end
            OP_POLL: begin
              doorbell_nxt = 1'b0;
              ptr_nxt      = '0;
              ram_rd_addr  = '0;
              if (limit == '0) begin
                pkind_nxt = KIND_DONE;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // send: check the word read back, then store
      ST_LOOK: begin
        if (send_ok && (data_r != '0)) begin
          ram_wr_en      = 1'b1;
          vld_nxt[idx_r] = 1'b1;
          doorbell_nxt   = 1'b1;
        end
        pkind_nxt = KIND_STATUS;
        pacc_nxt  = send_ok;
        state_nxt = ST_EMIT;
      end

      // poll: one mailbox per cycle until an entry is found
      ST_SCAN: begin
        if (hit) begin
          pkind_nxt = KIND_ENTRY;
          pidx_nxt  = IDX_W'(ptr_r);
          pdata_nxt = ram_rd_data;
          plast_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          ptr_nxt = ptr_inc;
          if (ptr_inc == limit) begin
            pkind_nxt = KIND_DONE;
            pidx_nxt  = '0;
            pdata_nxt = '0;
            plast_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            ram_rd_addr = ptr_inc[AW-1:0];
          end
        end
      end

      // load the result register, then resume
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pkind_r;
          out_acc_nxt   = pacc_r;
          out_idx_nxt   = pidx_r;
          out_data_nxt  = pdata_r;
          out_bell_nxt  = doorbell_r;
          out_last_nxt  = plast_r;
          if (plast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_inc;
            if (ptr_inc == limit) begin
              pkind_nxt = KIND_DONE;
              pidx_nxt  = '0;
              pdata_nxt = '0;
              plast_nxt = 1'b1;
            end else begin
              ram_rd_addr = ptr_inc[AW-1:0];
              state_nxt   = ST_SCAN;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      doorbell_r     <= 1'b0;
      vld_r          <= '0;
      mark_r         <= '0;
      out_valid_r    <= 1'b0;
      active_count_r <= CNT_W'(32);
    end else begin
      state_r     <= state_nxt;
      doorbell_r  <= doorbell_nxt;
      vld_r       <= vld_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        active_count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    inside_r   <= inside_nxt;
    data_r     <= data_nxt;
    ptr_r      <= ptr_nxt;
    pkind_r    <= pkind_nxt;
    pacc_r     <= pacc_nxt;
    pidx_r     <= pidx_nxt;
    pdata_r    <= pdata_nxt;
    plast_r    <= plast_nxt;
    out_kind_r <= out_kind_nxt;
    out_acc_r  <= out_acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_data_r <= out_data_nxt;
    out_bell_r <= out_bell_nxt;
    out_last_r <= out_last_nxt;
  end

  // outputs
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_bell_r, out_data_r, out_idx_r, out_acc_r};

endmodule

// ===== sim/dual_port_mailbox_table_core_test.sv =====
// ----------------------------------------------------------------------------
// dual_port_mailbox_table_core_test
// Self-checking bench for the mailbox table core.
// ----------------------------------------------------------------------------
// A queue-fed driver offers request words and a monitor checks every result
// word against a shadow copy of the mailbox table, the handler marks, the
// doorbell and the poll scan length. A directed opening covers busy and empty
// sends, zero posts, mark changes and scan length extremes. Random phases
// follow under changing back-pressure, plus one long receiver stall.
module dual_port_mailbox_table_core_test;
  import dpmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE = 32;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [15:0] data;
    logic        present;
  } mbox_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [4:0]  entry_idx;
    logic [15:0] entry_data;
    logic        bell;
    logic        last;
  } mbox_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic [23:0] out_tdata;

  // Shadow of the block state
  logic [15:0] mbox_word [TABLE_SIZE];
  logic        handler_mark [TABLE_SIZE];
  logic        doorbell;
  logic [5:0]  scan_count;

  mbox_req_t   mailbox_requests [$];
  mbox_reply_t expected_replies [$];
  mbox_req_t   offered_req;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned stall_kick = 0;
  int unsigned stall_seen = 0;
  int unsigned error_count = 0;

  dual_port_mailbox_table_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mbox_req_t mk_req(logic [1:0] op, logic [4:0] idx,
                                       logic [15:0] data, logic present);
    mbox_req_t r;
    r.op      = op;
    r.idx     = idx;
    r.data    = data;
    r.present = present;
    return r;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic push_reply(input logic [1:0] kind, input logic acc,
                            input logic [4:0] eidx, input logic [15:0] edata,
                            input logic last);
    mbox_reply_t e;
    e.kind       = kind;
    e.accepted   = acc;
    e.entry_idx  = eidx;
    e.entry_data = edata;
    e.bell       = doorbell;
    e.last       = last;
    expected_replies.push_back(e);
  endtask

  // Update the shadow table for one accepted request and queue its replies.
  // The 5-bit index never reaches past a 32-entry table.
  task automatic apply_mailbox_request(input mbox_req_t r);
    logic        acc;
    int unsigned limit;
    acc = 1'b0;
    case (r.op)
      OP_SEND: begin
        if (mbox_word[r.idx] == '0) begin
          acc = 1'b1;
          if (r.data != '0) begin
            mbox_word[r.idx] = r.data;
            doorbell = 1'b1;
          end
        end
        push_reply(KIND_STATUS, acc, '0, '0, 1'b1);
      end
      OP_CLEAR, OP_REGISTER: begin
        mbox_word[r.idx] = '0;
        if (r.op == OP_REGISTER) handler_mark[r.idx] = r.present;
        push_reply(KIND_ACK, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        // poll: scan length saturates at the table size
        limit = (scan_count > TABLE_SIZE) ? TABLE_SIZE : scan_count;
        doorbell = 1'b0;
        for (int unsigned i = 0; i < limit; i++) begin
          if (handler_mark[i] && mbox_word[i] != '0)
            push_reply(KIND_ENTRY, 1'b0, i[4:0], mbox_word[i], 1'b0);
        end
        push_reply(KIND_DONE, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Driver: predict on acceptance, then offer the next queued word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      foreach (mbox_word[i]) begin
        mbox_word[i]    = '0;
        handler_mark[i] = 1'b0;
      end
      doorbell = 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_mailbox_request(offered_req);
      if (!in_tvalid || in_tready) begin
        if (mailbox_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_req = mailbox_requests.pop_front();
          in_tuser  <= offered_req.op;
          in_tdata  <= {2'b00, offered_req.present, offered_req.data, offered_req.idx};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, started by a kick and counted down here
  always @(posedge clk) begin
    if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= 300;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    mbox_reply_t got;
    mbox_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind       = out_tuser;
        got.accepted   = out_tdata[0];
        got.entry_idx  = out_tdata[5:1];
        got.entry_data = out_tdata[21:6];
        got.bell       = out_tdata[22];
        got.last       = out_tlast;
        if (expected_replies.size() == 0) begin
          note_error($sformatf("unexpected result word kind=%0d tdata=%h", out_tuser,
                               out_tdata));
        end else begin
          want = expected_replies.pop_front();
          if (got !== want)
            note_error($sformatf({"result mismatch: expected kind=%0d acc=%0b idx=%0d ",
                                  "data=%h bell=%0b last=%0b, got kind=%0d acc=%0b ",
                                  "idx=%0d data=%h bell=%0b last=%0b"},
                                 want.kind, want.accepted, want.entry_idx,
                                 want.entry_data, want.bell, want.last,
                                 got.kind, got.accepted, got.entry_idx,
                                 got.entry_data, got.bell, got.last));
        end
      end
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Random request: mostly a few hot mailboxes so sends meet busy words and
  // polls find marked entries; the rest spread over the whole table
  function automatic mbox_req_t random_req();
    int unsigned pick;
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [15:0] data;
    pick = $urandom_range(99);
    if (pick < 40)      op = OP_SEND;
    else if (pick < 52) op = OP_CLEAR;
    else if (pick < 72) op = OP_REGISTER;
    else                op = OP_POLL;
    idx = ($urandom_range(99) < 70) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 10)      data = 16'h0000;
    else if (pick < 15) data = 16'h8000;
    else if (pick < 20) data = 16'h7FFF;
    else if (pick < 25) data = 16'hFFFF;
    else                data = 16'($urandom);
    return mk_req(op, idx, data, $urandom_range(99) < 80);
  endfunction

  task automatic queue_req(input mbox_req_t r);
    @(negedge clk);
    mailbox_requests.push_back(r);
  endtask

  task automatic queue_random(input int unsigned count);
    @(negedge clk);
    repeat (count) mailbox_requests.push_back(random_req());
  endtask

  // Sender holds off until every expected word has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (mailbox_requests.size() != 0 || in_tvalid || expected_replies.size() != 0);
  endtask

  task automatic write_scan_count(input logic [5:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    scan_count  = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    scan_count = 6'd32;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the reset scan length
    queue_req(mk_req(OP_REGISTER, 5'd0, 16'h0000, 1'b1));
    queue_req(mk_req(OP_REGISTER, 5'd31, 16'hFFFF, 1'b1));
    queue_req(mk_req(OP_SEND, 5'd0, 16'h7FFF, 1'b0));
    queue_req(mk_req(OP_SEND, 5'd0, 16'h1234, 1'b1));   // busy, refused
    queue_req(mk_req(OP_SEND, 5'd31, 16'h8000, 1'b0));
    queue_req(mk_req(OP_SEND, 5'd5, 16'h0000, 1'b0));   // zero post, nothing stored
    queue_req(mk_req(OP_SEND, 5'd31, 16'hFFFF, 1'b1));  // busy, refused
    queue_req(mk_req(OP_SEND, 5'd17, 16'hAAAA, 1'b0));  // no handler mark
    queue_req(mk_req(OP_POLL, 5'd31, 16'hFFFF, 1'b1));
    queue_req(mk_req(OP_POLL, 5'd0, 16'h0000, 1'b0));   // doorbell already low
    queue_req(mk_req(OP_SEND, 5'd7, 16'h0000, 1'b1));   // zero post leaves doorbell low
    queue_req(mk_req(OP_REGISTER, 5'd0, 16'h5555, 1'b0));
    queue_req(mk_req(OP_SEND, 5'd0, 16'h0001, 1'b0));
    queue_req(mk_req(OP_CLEAR, 5'd31, 16'h0000, 1'b1));
    queue_req(mk_req(OP_POLL, 5'd0, 16'h0000, 1'b0));
    queue_req(mk_req(OP_REGISTER, 5'd17, 16'h0000, 1'b1));
    queue_req(mk_req(OP_SEND, 5'd17, 16'hFFFF, 1'b0));
    queue_req(mk_req(OP_REGISTER, 5'd30, 16'h0000, 1'b1));
    queue_req(mk_req(OP_SEND, 5'd30, 16'h4321, 1'b0));
    wait_drained();

    // Scan length extremes: nothing scanned, then an oversized count
    write_scan_count(6'd0);
    queue_req(mk_req(OP_POLL, 5'd0, 16'h0000, 1'b0));
    wait_drained();
    write_scan_count(6'd63);
    queue_req(mk_req(OP_SEND, 5'd1, 16'h00FF, 1'b0));
    queue_req(mk_req(OP_POLL, 5'd31, 16'hFFFF, 1'b1));
    wait_drained();

    // Random phases under changing back-pressure
    write_scan_count(6'd32);
    send_idle_pct <= 21;
    recv_idle_pct <= 56;
    queue_random(25);
    wait_drained();

    write_scan_count(6'($urandom_range(1, 31)));
    send_idle_pct <= 56;
    recv_idle_pct <= 21;
    queue_random(25);
    wait_drained();

    write_scan_count(6'd1);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random(20);
    wait_drained();

    // Receiver stalls long while requests keep coming, so the core backs up
    write_scan_count(6'd63);
    @(posedge clk);
    stall_kick <= stall_kick + 1;
    queue_random(18);
    wait_drained();

    repeat (40) @(posedge clk);
    if (expected_replies.size() != 0)
      note_error($sformatf("%0d result words never arrived", expected_replies.size()));
    if (error_count == 0)
      $display("dual_port_mailbox_table_core regression: pass");
    else
      $display("dual_port_mailbox_table_core regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("dual_port_mailbox_table_core regression: fail");
    $finish;
  end

endmodule

// ===== dual_port_mailbox_table_core.f =====
src/dpmt_pkg.sv
src/dpmt_ram.sv
src/dual_port_mailbox_table_core.sv
sim/dual_port_mailbox_table_core_test.sv
